// ----- sv/sud_pkg.sv -----
package sud_pkg;

    localparam int SUD_WIDTH = 32;
    localparam int SUD_FIELD_W = 32;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_OVF  = 2'd2
    } t_status;

    typedef struct packed {
        logic    neg_q;
        logic    neg_r;
        t_status status;
    } t_meta;

endpackage

// ----- sv/sud_prep.sv -----
module sud_prep
    import sud_pkg::*;
#(
    parameter int WIDTH = SUD_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_req_type,
    input  logic [SUD_FIELD_W-1:0] i_dividend,
    input  logic [SUD_FIELD_W-1:0] i_divisor,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [WIDTH-1:0]       o_shf,
    output logic [WIDTH-1:0]       o_div,
    output t_meta                  o_meta
);

    localparam logic [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};

    logic             r_valid;
    logic [WIDTH-1:0] r_shf;
    logic [WIDTH-1:0] r_div;
    t_meta            r_meta;

    logic [WIDTH-1:0] n_shf;
    logic [WIDTH-1:0] n_div;
    t_meta            n_meta;
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] den;
    logic             nneg;
    logic             dneg;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        num   = WIDTH'(i_dividend);
        den   = WIDTH'(i_divisor);
        nneg  = i_req_type && num[WIDTH-1];
        dneg  = i_req_type && den[WIDTH-1];
        n_shf = nneg ? (WIDTH'(0) - num) : num;
        n_div = dneg ? (WIDTH'(0) - den) : den;
        n_meta.neg_q = nneg ^ dneg;
        n_meta.neg_r = nneg;
        if (den == '0) begin
            n_meta.status = ST_DIV0;
        end else if (i_req_type && num == MIN_VAL && den == '1) begin
            n_meta.status = ST_OVF;
        end else begin
            n_meta.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_shf  <= n_shf;
            r_div  <= n_div;
            r_meta <= n_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_shf   = r_shf;
    assign o_div   = r_div;
    assign o_meta  = r_meta;

endmodule

// ----- sv/sud_cell.sv -----
module sud_cell
    import sud_pkg::*;
#(
    parameter int WIDTH = SUD_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_rem,
    input  logic [WIDTH-1:0] i_shf,
    input  logic [WIDTH-1:0] i_div,
    input  t_meta            i_meta,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH-1:0] o_shf,
    output logic [WIDTH-1:0] o_div,
    output t_meta            o_meta
);

    logic             r_valid;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_shf;
    logic [WIDTH-1:0] r_div;
    t_meta            r_meta;

    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_shf;
    logic [WIDTH:0]   part;
    logic [WIDTH:0]   diff;
    logic             take;

    assign o_ready = !r_valid || i_ready;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        part  = {i_rem, i_shf[WIDTH-1]};
        diff  = part - {1'b0, i_div};
        take  = part >= {1'b0, i_div};
        n_rem = take ? diff[WIDTH-1:0] : part[WIDTH-1:0];
        n_shf = {i_shf[WIDTH-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_rem  <= n_rem;
            r_shf  <= n_shf;
            r_div  <= i_div;
            r_meta <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_shf   = r_shf;
    assign o_div   = r_div;
    assign o_meta  = r_meta;

endmodule

// ----- sv/sud_fix.sv -----
module sud_fix
    import sud_pkg::*;
#(
    parameter int WIDTH = SUD_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [WIDTH-1:0]       i_rem,
    input  logic [WIDTH-1:0]       i_quo,
    input  t_meta                  i_meta,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SUD_FIELD_W-1:0] o_quotient,
    output logic [SUD_FIELD_W-1:0] o_remainder,
    output logic [1:0]             o_status
);

    logic                   r_valid;
    logic [SUD_FIELD_W-1:0] r_quo;
    logic [SUD_FIELD_W-1:0] r_rem;
    t_status                r_status;

    logic [WIDTH-1:0]       q_fix;
    logic [WIDTH-1:0]       rem_fix;
    logic [SUD_FIELD_W-1:0] n_quo;
    logic [SUD_FIELD_W-1:0] n_rem;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        q_fix   = i_meta.neg_q ? (WIDTH'(0) - i_quo) : i_quo;
        rem_fix = i_meta.neg_r ? (WIDTH'(0) - i_rem) : i_rem;
        if (i_meta.status == ST_DIV0) begin
            n_quo = '0;
            n_rem = '0;
        end else begin
            n_quo = SUD_FIELD_W'(q_fix);
            n_rem = SUD_FIELD_W'(rem_fix);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_quo    <= n_quo;
            r_rem    <= n_rem;
            r_status <= i_meta.status;
        end
    end

    assign o_valid     = r_valid;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
    assign o_status    = r_status;

endmodule

// ----- sv/signed_unsigned_integer_divider.sv -----
// channel   handshake              payload
// request   i_valid / o_ready      i_req_type, i_dividend, i_divisor
// result    o_valid / i_ready      o_quotient, o_remainder, o_status
//
// one request per cycle while i_ready keeps results moving; stages are the sign stage, one cell
// per quotient bit, and the sign fix and output stage
// every stage has its own valid bit, so bubbles close up under a stall
// and requests keep entering while a result waits to be taken
// synchronous active-low reset clears the valid bits only
module signed_unsigned_integer_divider
    import sud_pkg::*;
#(
    parameter int WIDTH = SUD_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_req_type,
    input  logic [SUD_FIELD_W-1:0] i_dividend,
    input  logic [SUD_FIELD_W-1:0] i_divisor,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [SUD_FIELD_W-1:0] o_quotient,
    output logic [SUD_FIELD_W-1:0] o_remainder,
    output logic [1:0]             o_status
);

    logic             vld [WIDTH+1];
    logic             rdy [WIDTH+1];
    logic [WIDTH-1:0] rem [WIDTH+1];
    logic [WIDTH-1:0] shf [WIDTH+1];
    logic [WIDTH-1:0] dvs [WIDTH+1];
    t_meta            meta [WIDTH+1];

    sud_prep #(
        .WIDTH(WIDTH)
    ) u_prep (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (vld[0]),
        .i_ready    (rdy[0]),
        .o_shf      (shf[0]),
        .o_div      (dvs[0]),
        .o_meta     (meta[0])
    );

    assign rem[0] = '0;

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        sud_cell #(
            .WIDTH(WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .o_ready (rdy[g]),
            .i_rem   (rem[g]),
            .i_shf   (shf[g]),
            .i_div   (dvs[g]),
            .i_meta  (meta[g]),
            .o_valid (vld[g+1]),
            .i_ready (rdy[g+1]),
            .o_rem   (rem[g+1]),
            .o_shf   (shf[g+1]),
            .o_div   (dvs[g+1]),
            .o_meta  (meta[g+1])
        );
    end

    sud_fix #(
        .WIDTH(WIDTH)
    ) u_fix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (vld[WIDTH]),
        .o_ready     (rdy[WIDTH]),
        .i_rem       (rem[WIDTH]),
        .i_quo       (shf[WIDTH]),
        .i_meta      (meta[WIDTH]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder),
        .o_status    (o_status)
    );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import sud_pkg::*;

    localparam int W = SUD_FIELD_W;
    localparam int N_RANDOM = 900;
    localparam int DRAIN_CYCLES = SUD_WIDTH + 20;
    localparam logic REQ_UNSIGNED = 1'b0;
    localparam logic REQ_SIGNED = 1'b1;
    localparam logic TYPED = 1'b1;
    localparam logic PREDICT = 1'b0;
    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [W-1:0] quotient;
        logic [W-1:0] remainder;
        t_status      status;
    } t_div_result;

    typedef struct packed {
        logic         req_type;
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        logic         typed;
        t_div_result  result;
    } t_stim_row;

    localparam int N_DIRECTED = 21;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{REQ_UNSIGNED, 32'h0000_0000, 32'h0000_0001, TYPED, '{32'h0, 32'h0, ST_OK}},
        '{REQ_UNSIGNED, 32'hFFFF_FFFF, 32'h0000_0001, TYPED, '{32'hFFFF_FFFF, 32'h0, ST_OK}},
        '{REQ_UNSIGNED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, '{32'h1, 32'h0, ST_OK}},
        '{REQ_UNSIGNED, 32'h0000_0005, 32'h0000_0000, TYPED, '{32'h0, 32'h0, ST_DIV0}},
        '{REQ_SIGNED,   32'h0000_0005, 32'h0000_0000, TYPED, '{32'h0, 32'h0, ST_DIV0}},
        '{REQ_UNSIGNED, 32'h0000_0000, 32'h0000_0000, TYPED, '{32'h0, 32'h0, ST_DIV0}},
        '{REQ_SIGNED,   32'h8000_0000, 32'hFFFF_FFFF, TYPED,
          '{32'h8000_0000, 32'h0, ST_OVF}},
        '{REQ_UNSIGNED, 32'h8000_0000, 32'hFFFF_FFFF, TYPED,
          '{32'h0, 32'h8000_0000, ST_OK}},
        '{REQ_SIGNED,   32'h0000_0007, 32'h0000_0002, PREDICT, '{32'h0, 32'h0, ST_OK}},
        '{REQ_SIGNED,   32'hFFFF_FFF9, 32'h0000_0002, PREDICT, '{32'h0, 32'h0, ST_OK}},
        '{REQ_SIGNED,   32'h0000_0007, 32'hFFFF_FFFE, PREDICT, '{32'h0, 32'h0, ST_OK}},
        '{REQ_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFE, PREDICT, '{32'h0, 32'h0, ST_OK}},
        '{REQ_SIGNED,   32'h8000_0000, 32'h0000_0001, TYPED,
          '{32'h8000_0000, 32'h0, ST_OK}},
        '{REQ_SIGNED,   32'h8000_0000, 32'h8000_0000, TYPED, '{32'h1, 32'h0, ST_OK}},
        '{REQ_SIGNED,   32'h7FFF_FFFF, 32'h8000_0000, TYPED,
          '{32'h0, 32'h7FFF_FFFF, ST_OK}},
        '{REQ_UNSIGNED, 32'h1234_5678, 32'h0000_03E8, PREDICT, '{32'h0, 32'h0, ST_OK}},
        '{REQ_SIGNED,   32'h7FFF_FFFF, 32'hFFFF_FFFF, TYPED,
          '{32'h8000_0001, 32'h0, ST_OK}},
        '{REQ_UNSIGNED, 32'h0000_0003, 32'h0000_0007, TYPED, '{32'h0, 32'h3, ST_OK}},
        '{REQ_SIGNED,   32'hFFFF_FFFF, 32'h7FFF_FFFF, TYPED,
          '{32'h0, 32'hFFFF_FFFF, ST_OK}},
        '{REQ_UNSIGNED, 32'hAAAA_AAAA, 32'h5555_5555, PREDICT, '{32'h0, 32'h0, ST_OK}},
        '{REQ_SIGNED,   32'h0000_0000, 32'hFFFF_FFFF, TYPED, '{32'h0, 32'h0, ST_OK}}
    };

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_valid = 1'b0;
    logic         o_ready;
    logic         i_req_type = 1'b0;
    logic [W-1:0] i_dividend = '0;
    logic [W-1:0] i_divisor = '0;
    logic         o_valid;
    logic         i_ready = 1'b0;
    logic [W-1:0] o_quotient;
    logic [W-1:0] o_remainder;
    logic [1:0]   o_status;

    t_div_result pending_results [$];
    int          failures = 0;
    bit          sender_no_idle = 1'b0;

    signed_unsigned_integer_divider u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder),
        .o_status    (o_status)
    );

    always #2 i_clk = ~i_clk;

    function automatic t_div_result predict_division(input logic rt,
                                                     input logic [W-1:0] a,
                                                     input logic [W-1:0] b);
        t_div_result res;
        logic         a_neg;
        logic         b_neg;
        logic [W-1:0] mag_a;
        logic [W-1:0] mag_b;
        res.quotient = '0;
        res.remainder = '0;
        res.status = ST_OK;
        if (b == '0) begin
            res.status = ST_DIV0;
        end else if (rt == REQ_UNSIGNED) begin
            res.quotient = a / b;
            res.remainder = a % b;
        end else begin
            a_neg = a[W-1];
            b_neg = b[W-1];
            mag_a = a_neg ? -a : a;
            mag_b = b_neg ? -b : b;
            res.quotient = mag_a / mag_b;
            res.remainder = mag_a % mag_b;
            if (a_neg != b_neg) res.quotient = -res.quotient;
            if (a_neg) res.remainder = -res.remainder;
            if (a == MOST_NEG && b == ALL_ONES) res.status = ST_OVF;
        end
        return res;
    endfunction

    function automatic logic [W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'h1;
            2: return ALL_ONES;
            3: return MOST_NEG;
            4: return MOST_NEG - 1;
            5: return 32'h1 << $urandom_range(0, W - 1);
            6: return $urandom_range(0, 255);
            7: return -$urandom_range(1, 255);
            default: return $urandom;
        endcase
    endfunction

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_request(input logic rt, input logic [W-1:0] a,
                                input logic [W-1:0] b, input t_div_result exp_res);
        int gap;
        gap = sender_no_idle ? 0 : $urandom_range(0, 9);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= rt;
        i_dividend <= a;
        i_divisor <= b;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pending_results.push_back(exp_res);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // result side
    initial begin
        int          gap;
        int          results_seen;
        t_div_result exp_res;
        results_seen = 0;
        while (i_rst_n !== 1'b1) @(negedge i_clk);
        forever begin
            if (results_seen == 150) gap = 400;
            else if (results_seen >= 400 && results_seen < 550) gap = 0;
            else gap = $urandom_range(0, 9);
            @(negedge i_clk);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: q=%h r=%h s=%0d",
                       o_quotient, o_remainder, o_status);
                failures++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_quotient !== exp_res.quotient) begin
                    $error("quotient: expected %h, got %h", exp_res.quotient, o_quotient);
                    failures++;
                end
                if (o_remainder !== exp_res.remainder) begin
                    $error("remainder: expected %h, got %h", exp_res.remainder, o_remainder);
                    failures++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, o_status);
                    failures++;
                end
            end
        end
    end

    // request side
    initial begin
        logic         rt;
        logic [W-1:0] a;
        logic [W-1:0] b;
        t_div_result  exp_res;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED_ROWS[i].typed) exp_res = DIRECTED_ROWS[i].result;
            else exp_res = predict_division(DIRECTED_ROWS[i].req_type,
                                            DIRECTED_ROWS[i].dividend,
                                            DIRECTED_ROWS[i].divisor);
            send_request(DIRECTED_ROWS[i].req_type, DIRECTED_ROWS[i].dividend,
                         DIRECTED_ROWS[i].divisor, exp_res);
        end
        wait_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            sender_no_idle = (i >= 300 && i < 450);
            if (i == 600) wait_drained();
            rt = 1'($urandom_range(0, 1));
            a = random_operand();
            b = random_operand();
            // keep divide by zero occasional
            if (b == '0 && $urandom_range(0, 3) != 0) b = $urandom | 32'h1;
            if ($urandom_range(0, 19) == 0) begin
                rt = REQ_SIGNED;
                a = MOST_NEG;
                b = ALL_ONES;
            end
            send_request(rt, a, b, predict_division(rt, a, b));
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("signed_unsigned_integer_divider test passed");
        end else begin
            $display("signed_unsigned_integer_divider test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("signed_unsigned_integer_divider test failed");
        $finish;
    end

endmodule
